### rtl/nsc_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence checker.
package nsc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  verdict_t;
  typedef logic [4:0]  count_t;
  typedef logic [39:0] tag_t;

  localparam int CfgDataW  = 40;
  localparam int CfgIndexW = 1;

  localparam logic [CfgIndexW-1:0] REG_SENTENCE_TAG    = 1'd0;
  localparam logic [CfgIndexW-1:0] REG_EXPECTED_FIELDS = 1'd1;

  localparam verdict_t VERDICT_OK        = 2'd0;
  localparam verdict_t VERDICT_BAD_SUM   = 2'd1;
  localparam verdict_t VERDICT_BAD_COUNT = 2'd2;
  localparam verdict_t VERDICT_OVERFLOW  = 2'd3;

  localparam byte_t CHAR_NUL    = 8'h00;
  localparam byte_t CHAR_DOLLAR = 8'h24;
  localparam byte_t CHAR_STAR   = 8'h2A;
  localparam byte_t CHAR_COMMA  = 8'h2C;
  localparam byte_t CHAR_ZERO   = 8'h30;
  localparam byte_t CHAR_UPPER_A = 8'h41;

  // "GPRMC", first character in the top byte.
  localparam tag_t   TAG_RESET    = 40'h4750524D43;
  localparam count_t FIELDS_RESET = 5'd12;
  localparam count_t COUNT_MAX    = 5'd31;

  // Uppercase hex spelling of one nibble.
  function automatic byte_t hex_char(input logic [3:0] nib);
    byte_t ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'd0, nib};
    end else begin
      ch = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

### rtl/nsc_if.sv
// Valid/ready channels for received bytes and for sentence verdicts.
interface nsc_byte_if import nsc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsc_result_if import nsc_pkg::*; ();
  logic     valid;
  logic     ready;
  verdict_t verdict;
  byte_t    computed_checksum;
  count_t   comma_count;

  modport source (output valid, output verdict, output computed_checksum,
                  output comma_count, input ready);
  modport sink (input valid, input verdict, input computed_checksum,
                input comma_count, output ready);
endinterface

### rtl/nmea_sentence_checker_unit.sv
// NMEA sentence checker: tag match, checksum, field count and body length checks.
//
// The checker takes one received byte per clock unless the byte channel is held off.
// Each byte updates the registered sentence state; a sentence that gets past its
// tag comma and is not restarted by a '$' ends in one word on the result channel,
// loaded into the output register at the clock edge that accepts its last byte and
// shown on the next cycle. The byte channel is held off in every cycle where the
// output register is full and its word is not being taken, so a verdict that waits
// stalls the byte stream until it leaves. A '$' restarts a sentence at any point,
// and a zero byte is dropped. The user must write the sentence tag and expected field
// count via the configuration port only while idle; the block does not enforce it.
module nmea_sentence_checker_unit
  import nsc_pkg::*;
#(
  parameter int MAX_BODY = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  nsc_byte_if.sink             rx,
  nsc_result_if.source         res
);

  localparam int BodyW = $clog2(MAX_BODY + 1);
  localparam logic [BodyW-1:0] BodyLimit = BodyW'(MAX_BODY);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_COMMA = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_HEX1  = 3'd4;
  localparam logic [2:0] PH_HEX2  = 3'd5;

  tag_t   sentence_tag;
  count_t expected_fields;

  logic [2:0]       phase, phase_next;
  logic [2:0]       tag_position, tag_position_next;
  byte_t            running_xor, running_xor_next;
  count_t           commas_seen, commas_seen_next;
  logic [BodyW-1:0] body_length, body_length_next;
  byte_t            first_hex_digit, first_hex_digit_next;

  logic     accept;
  logic     emit;
  verdict_t verdict_next;
  byte_t    c;
  byte_t    want;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = !res.valid || res.ready;
  assign c        = rx.rx_byte;

  always_comb begin
    case (tag_position)
      3'd0:    want = sentence_tag[39:32];
      3'd1:    want = sentence_tag[31:24];
      3'd2:    want = sentence_tag[23:16];
      3'd3:    want = sentence_tag[15:8];
      default: want = sentence_tag[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    tag_position_next    = tag_position;
    running_xor_next     = running_xor;
    commas_seen_next     = commas_seen;
    body_length_next     = body_length;
    first_hex_digit_next = first_hex_digit;
    emit                 = 1'b0;
    verdict_next         = VERDICT_OK;
    if (accept && c != CHAR_NUL) begin
      if (c == CHAR_DOLLAR) begin
        phase_next           = PH_TAG;
        tag_position_next    = 3'd0;
        running_xor_next     = 8'd0;
        commas_seen_next     = 5'd0;
        body_length_next     = '0;
        first_hex_digit_next = 8'd0;
      end else begin
        case (phase)
          PH_TAG: begin
            if (c != want) begin
              phase_next = PH_HUNT;
            end else begin
              running_xor_next  = running_xor ^ c;
              tag_position_next = tag_position + 3'd1;
              if (tag_position == 3'd4) begin
                phase_next = PH_COMMA;
              end
            end
          end
          PH_COMMA: begin
            if (c != CHAR_COMMA) begin
              phase_next = PH_HUNT;
            end else begin
              running_xor_next = running_xor ^ c;
              phase_next       = PH_BODY;
            end
          end
          PH_BODY: begin
            if (c == CHAR_STAR) begin
              // A zero expected count can never match, since the sum is at least one.
              if ({1'b0, commas_seen} + 6'd1 != {1'b0, expected_fields}) begin
                emit         = 1'b1;
                verdict_next = VERDICT_BAD_COUNT;
                phase_next   = PH_HUNT;
              end else begin
                phase_next = PH_HEX1;
              end
            end else begin
              running_xor_next = running_xor ^ c;
              if (c == CHAR_COMMA && commas_seen != COUNT_MAX) begin
                commas_seen_next = commas_seen + 5'd1;
              end
              if (body_length >= BodyLimit) begin
                emit         = 1'b1;
                verdict_next = VERDICT_OVERFLOW;
                phase_next   = PH_HUNT;
              end else begin
                body_length_next = body_length + BodyW'(1);
              end
            end
          end
          PH_HEX1: begin
            first_hex_digit_next = c;
            phase_next           = PH_HEX2;
          end
          PH_HEX2: begin
            emit       = 1'b1;
            phase_next = PH_HUNT;
            if (first_hex_digit == hex_char(running_xor[7:4]) &&
                c == hex_char(running_xor[3:0])) begin
              verdict_next = VERDICT_OK;
            end else begin
              verdict_next = VERDICT_BAD_SUM;
            end
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sentence_tag    <= TAG_RESET;
      expected_fields <= FIELDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENTENCE_TAG:    sentence_tag    <= cfg_wdata;
        REG_EXPECTED_FIELDS: expected_fields <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      tag_position    <= 3'd0;
      running_xor     <= 8'd0;
      commas_seen     <= 5'd0;
      body_length     <= '0;
      first_hex_digit <= 8'd0;
    end else begin
      phase           <= phase_next;
      tag_position    <= tag_position_next;
      running_xor     <= running_xor_next;
      commas_seen     <= commas_seen_next;
      body_length     <= body_length_next;
      first_hex_digit <= first_hex_digit_next;
    end
  end

  // Output register: a new verdict can only be loaded when the old word leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.verdict           <= verdict_next;
      res.computed_checksum <= running_xor_next;
      res.comma_count       <= commas_seen_next;
    end
  end

  a_dollar_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && c == CHAR_DOLLAR) |=> (phase == PH_TAG && running_xor == 8'd0 &&
                                      commas_seen == 5'd0))
    else $error("dollar sign did not restart the sentence");

  a_emit_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == PH_HUNT && res.valid))
    else $error("verdict did not end the sentence");

  a_body_bounded: assert property (@(posedge clk) disable iff (rst)
    body_length <= BodyLimit)
    else $error("body length ran past its limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !emit)
    else $error("verdict loaded over a word not yet taken");

endmodule
